/* rtl/ffra_pkg.sv */
// ffra_pkg: types and constants shared by the first-fit region allocator.
// Used by first_fit_region_allocator_core; no dependencies.
`default_nettype none
package ffra_pkg;

  localparam int unsigned FFRA_MAX_AREAS  = 64;
  localparam int unsigned FFRA_PAGE_SHIFT = 13;

  localparam logic [31:0] WINDOW_BASE_RST = 32'h0100_0000;
  localparam logic [31:0] WINDOW_LEN_RST  = 32'h7F00_0000;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_BASE   = 1'b0,
    CFG_WINDOW_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BACKING   = 3'd4,
    ST_UNALIGNED = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_NULL      = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_CHK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FIT,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_CMP,
    S_MOV_RD,
    S_MOV_WR,
    S_RESP
  } state_e;

  typedef enum logic {
    KIND_MAP   = 1'b0,
    KIND_UNMAP = 1'b1
  } kind_e;

endpackage
`default_nettype wire

/* rtl/first_fit_region_allocator_core.sv */
// first_fit_region_allocator_core: first-fit area allocator over a sorted table.
// Depends on ffra_pkg and ffra_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | kind, request_size, request_address,
//          |           |                         | backing_failed
//  out     | output    | out_valid_o/out_stall_i | status, granted_address
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time. A map scans the sorted table for the first gap that fits and shifts
// later entries up to insert; an unmap scans for the address and shifts later entries down,
// both walked through the single RAM read port one entry at a time.
// Reset empties the table by clearing the entry count; no clearing pass.
// The result register lets a new item be accepted while a result is stalled.
`default_nettype none
module first_fit_region_allocator_core #(
  parameter int unsigned MAX_AREAS  = ffra_pkg::FFRA_MAX_AREAS,
  parameter int unsigned PAGE_SHIFT = ffra_pkg::FFRA_PAGE_SHIFT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           kind_i,
  input  wire logic [31:0]                    request_size_i,
  input  wire logic [31:0]                    request_address_i,
  input  wire logic                           backing_failed_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [2:0]                     status_o,
  output logic      [31:0]                    granted_address_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);
  import ffra_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_AREAS);
  localparam int unsigned CNT_W = $clog2(MAX_AREAS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_AREAS);
  localparam logic [32:0]      PAGE_BYTES = 33'd1 << PAGE_SHIFT;
  localparam logic [32:0]      PAGE_MASK  = PAGE_BYTES - 33'd1;
  localparam logic [32:0]      ADDR_TOP   = 33'h1_0000_0000;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      wbase_q, wbase_d;
  logic [31:0]      wlen_q, wlen_d;

  logic [31:0]      req_q, req_d;
  logic             bf_q, bf_d;
  logic [31:0]      del_addr_q, del_addr_d;
  logic             del_bf_q, del_bf_d;
  logic [32:0]      size_q, size_d;
  logic [32:0]      wend_q, wend_d;
  logic [32:0]      cand_q, cand_d;
  logic [33:0]      sum_q, sum_d;
  logic [31:0]      len_q, len_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] j_q, j_d;
  status_e          res_status_q, res_status_d;
  logic [31:0]      res_addr_q, res_addr_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [31:0]      out_addr_q, out_addr_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [63:0]      ram_wdata, ram_rdata;
  logic [31:0]      rd_start, rd_len;

  logic [32:0]      size_calc, wsum;
  logic [33:0]      fit_sum, len_sum;
  logic [CNT_W-1:0] j_next;
  logic             in_accept;

  ffra_ram #(
    .WIDTH (64),
    .DEPTH (MAX_AREAS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_start = ram_rdata[63:32];
  assign rd_len   = ram_rdata[31:0];

  assign in_stall_o        = (state_q != S_IDLE);
  assign in_accept         = in_valid_i && !in_stall_o;
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;

  assign size_calc = ({1'b0, req_q} + PAGE_MASK) & ~PAGE_MASK;
  assign wsum      = {1'b0, wbase_q} + {1'b0, wlen_q};
  assign fit_sum   = {1'b0, cand_q} + {1'b0, size_q};
  assign len_sum   = {1'b0, size_q} + {1'b0, PAGE_BYTES};
  assign j_next    = j_q + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    wbase_d      = wbase_q;
    wlen_d       = wlen_q;
    req_d        = req_q;
    bf_d         = bf_q;
    del_addr_d   = del_addr_q;
    del_bf_d     = del_bf_q;
    size_d       = size_q;
    wend_d       = wend_q;
    cand_d       = cand_q;
    sum_d        = sum_q;
    len_d        = len_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    j_d          = j_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = j_q[IDX_W-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[IDX_W-1:0];

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_BASE:   wbase_d = cfg_data_i;
        CFG_WINDOW_LENGTH: wlen_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d      = request_size_i;
          bf_d       = backing_failed_i;
          del_addr_d = request_address_i;
          del_bf_d   = 1'b0;
          res_addr_d = '0;
          state_d    = (kind_e'(kind_i) == KIND_UNMAP) ? S_DEL_CHK : S_MAP_CHK;
        end
      end
      S_MAP_CHK: begin
        size_d = size_calc;
        wend_d = wsum[32] ? ADDR_TOP : wsum;
        cand_d = {1'b0, wbase_q};
        idx_d  = '0;
        pos_d  = count_q;
        if (size_calc == '0 || size_calc > {1'b0, wlen_q}) begin
          res_status_d = ST_BAD_SIZE;
          state_d      = S_RESP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          state_d = S_FIT;
        end else begin
          ram_re  = 1'b1;
          sum_d   = fit_sum;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sum_q < {2'b00, rd_start}) begin
          pos_d   = idx_q;
          state_d = S_FIT;
        end else begin
          cand_d  = {1'b0, rd_start} + {1'b0, rd_len};
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FIT: begin
        len_d = (len_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : len_sum[31:0];
        j_d   = count_q;
        if (fit_sum >= {1'b0, wend_q}) begin
          res_status_d = ST_NO_SPACE;
          state_d      = S_RESP;
        end else if (count_q >= MAX_CNT) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (j_q == pos_q) begin
          state_d = S_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(j_q - CNT_W'(1));
          state_d   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we  = 1'b1;
        j_d     = j_q - CNT_W'(1);
        state_d = S_INS_RD;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IDX_W-1:0];
        ram_wdata = {cand_q[31:0], len_q};
        count_d   = count_q + CNT_W'(1);
        if (bf_q) begin
          del_addr_d = cand_q[31:0];
          del_bf_d   = 1'b1;
          state_d    = S_DEL_CHK;
        end else begin
          res_status_d = ST_OK;
          res_addr_d   = cand_q[31:0];
          state_d      = S_RESP;
        end
      end
      S_DEL_CHK: begin
        idx_d = '0;
        if (del_addr_q == '0) begin
          res_status_d = del_bf_q ? ST_BACKING : ST_NULL;
          state_d      = S_RESP;
        end else if ((del_addr_q & PAGE_MASK[31:0]) != '0) begin
          res_status_d = del_bf_q ? ST_BACKING : ST_UNALIGNED;
          state_d      = S_RESP;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        if (idx_q == count_q) begin
          res_status_d = del_bf_q ? ST_BACKING : ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          ram_re  = 1'b1;
          state_d = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (rd_start == del_addr_q) begin
          j_d     = idx_q;
          state_d = S_MOV_RD;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_DEL_RD;
        end
      end
      S_MOV_RD: begin
        if (j_next >= count_q) begin
          count_d      = count_q - CNT_W'(1);
          res_status_d = del_bf_q ? ST_BACKING : ST_OK;
          state_d      = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_next[IDX_W-1:0];
          state_d   = S_MOV_WR;
        end
      end
      S_MOV_WR: begin
        ram_we  = 1'b1;
        j_d     = j_next;
        state_d = S_MOV_RD;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      wbase_q     <= WINDOW_BASE_RST;
      wlen_q      <= WINDOW_LEN_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      wbase_q     <= wbase_d;
      wlen_q      <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    bf_q         <= bf_d;
    del_addr_q   <= del_addr_d;
    del_bf_q     <= del_bf_d;
    size_q       <= size_d;
    wend_q       <= wend_d;
    cand_q       <= cand_d;
    sum_q        <= sum_d;
    len_q        <= len_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    j_q          <= j_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count above table depth");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_PUT |-> count_q < MAX_CNT)
    else $error("insert into a full table");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result raised outside the response step");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> out_addr_q == '0)
    else $error("nonzero address with a failure status");

endmodule
`default_nettype wire

/* rtl/ffra_ram.sv */
// ffra_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
